### sv/txrf_pkg.sv
// Shared types and codes for the transmit ring queue.
`default_nettype none
package txrf_pkg;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TXE  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       push_accepted;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       tx_irq_enable;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec_item;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
  } ctrl_status_t;

endpackage
`default_nettype wire

### sv/transmit_ring_fifo_with_irq_prime_top.sv
// Top level of the transmit ring queue with interrupt priming.
// The result strobe done is raised in the respond state, which follows the execute state.
// A new item is taken only in the idle state: each item runs the load, execute and respond sequence
// around the registered read port of the byte store before the next item is accepted.
// Reset: pointers and laps clear, prime sets, interrupt enable clears; store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module transmit_ring_fifo_with_irq_prime_top #(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire txrf_pkg::in_item_t  request,
  output logic                     done,
  output txrf_pkg::out_item_t      result
);

  txrf_pkg::ctrl_cmd_t    cmd;
  txrf_pkg::ctrl_status_t status;

  txrf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status)
  );

  txrf_dp #(.DEPTH(DEPTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .done    (done),
    .result  (result)
  );

  assign busy = status.busy;

endmodule
`default_nettype wire

### sv/txrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module txrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/txrf_ctrl.sv
// Controller state machine: sequences load, execute and respond.
`default_nettype none
module txrf_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output txrf_pkg::ctrl_cmd_t         cmd,
  output txrf_pkg::ctrl_status_t      status
);

  txrf_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      txrf_pkg::S_IDLE: if (start) state_next = txrf_pkg::S_EXEC;
      txrf_pkg::S_EXEC: state_next = txrf_pkg::S_RESP;
      txrf_pkg::S_RESP: state_next = txrf_pkg::S_IDLE;
      default:          state_next = txrf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= txrf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load_item  = (state == txrf_pkg::S_IDLE) && start;
  assign cmd.exec_item  = (state == txrf_pkg::S_EXEC);
  assign cmd.respond    = (state == txrf_pkg::S_RESP);
  assign status.busy    = (state != txrf_pkg::S_IDLE);

endmodule
`default_nettype wire

### sv/txrf_dp.sv
// Datapath: ring pointers with lap bits, prime and interrupt flags, byte store.
`default_nettype none
module txrf_dp #(
  parameter int DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire txrf_pkg::ctrl_cmd_t  cmd,
  input  wire txrf_pkg::in_item_t   request,
  output logic                      done,
  output txrf_pkg::out_item_t       result
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  txrf_pkg::in_item_t item;
  logic [AW-1:0] write_pos, read_pos;
  logic          write_lap, read_lap;
  logic          prime_flag, irq_enable_bit;
  logic          push_accepted, byte_valid;
  logic          has_room, is_empty, same_lap;
  logic          do_write, do_read;
  logic [7:0]    ram_rdata;

  assign same_lap = (write_lap == read_lap);
  assign has_room = ((write_pos >= read_pos) && same_lap) ||
                    ((write_pos < read_pos) && !same_lap);
  assign is_empty = (write_pos == read_pos) && same_lap;
  assign do_write = cmd.exec_item && (item.action == txrf_pkg::ACT_PUSH) && has_room;
  assign do_read  = cmd.exec_item && (item.action == txrf_pkg::ACT_TXE) && !is_empty;

  txrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (write_pos),
    .wdata (item.data_byte),
    .raddr (read_pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= request;
    end
    if (cmd.exec_item) begin
      push_accepted <= do_write;
      byte_valid    <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos      <= '0;
      read_pos       <= '0;
      write_lap      <= 1'b0;
      read_lap       <= 1'b0;
      prime_flag     <= 1'b1;
      irq_enable_bit <= 1'b0;
    end else if (cmd.exec_item) begin
      if (item.action == txrf_pkg::ACT_PUSH) begin
        if (prime_flag) irq_enable_bit <= 1'b1;
        if (has_room) begin
          if (write_pos == LAST_POS) begin
            write_pos <= '0;
            write_lap <= ~write_lap;
          end else begin
            write_pos <= write_pos + AW'(1);
          end
        end
      end else begin
        if (is_empty) begin
          prime_flag     <= 1'b1;
          irq_enable_bit <= 1'b0;
        end else begin
          prime_flag <= 1'b0;
          if (read_pos == LAST_POS) begin
            read_pos <= '0;
            read_lap <= ~read_lap;
          end else begin
            read_pos <= read_pos + AW'(1);
          end
        end
      end
    end
  end

  assign done                 = cmd.respond;
  assign result.push_accepted = push_accepted;
  assign result.byte_valid    = byte_valid;
  assign result.byte_out      = byte_valid ? ram_rdata : 8'h00;
  assign result.tx_irq_enable = irq_enable_bit;

endmodule
`default_nettype wire
